// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, codes and inter-module item types of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	// Product and sum width, quotient bits, divider working width.
	localparam int NW = 2 * DATA_WIDTH;
	localparam int QB = DATA_WIDTH + 1;
	localparam int CW = NW + FRAC_BITS + QB + 1;

	// Divider stages: one overflow check, then one quotient bit per stage.
	localparam int NS = QB + 1;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_SAT = 2'd1;
	localparam logic [1:0] STATUS_DZ  = 2'd2;

	localparam logic [CW-1:0] MAXPOS_C = CW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic [QB-1:0] BIG_C    = {1'b1, {DATA_WIDTH{1'b0}}};

	typedef struct packed {
		logic [1:0]    func;
		logic          dz;
		logic          neg_re;
		logic          neg_im;
		logic [CW-1:0] num_re;
		logic [CW-1:0] num_im;
		logic [NW-1:0] norm;
	} div_item_t;

	typedef struct packed {
		logic [1:0]    func;
		logic          dz;
		logic          neg_re;
		logic          neg_im;
		logic [CW-1:0] rem_re;
		logic [CW-1:0] rem_im;
		logic [QB-1:0] q_re;
		logic [QB-1:0] q_im;
		logic          ovf_re;
		logic          ovf_im;
		logic [NW-1:0] norm;
	} div_stage_t;

	typedef struct packed {
		logic          dz;
		logic          neg_re;
		logic          neg_im;
		logic [CW-1:0] mag_re;
		logic [CW-1:0] mag_im;
	} res_item_t;

endpackage

// ----- rtl/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Three pipeline stages: products, exact term sums, sign-magnitude split.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_ready,
	output div_item_t                    out_item
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic [1:0]                 func_s1;
	logic signed [NW-1:0]       p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	logic signed [DATA_WIDTH:0] sum_re_s1, sum_im_s1;

	logic [1:0]           func_s2;
	logic signed [NW:0]   re_s2, im_s2;
	logic [NW-1:0]        norm_s2;

	logic signed [NW:0] re_d, im_d;
	logic [NW-1:0]      mag_re, mag_im;
	logic [CW-1:0]      mag_re_w, mag_im_w;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1 <= func;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_bb_s1 <= b_re * b_re;
			p_cc_s1 <= b_im * b_im;
			if (func == FUNC_SUB) begin
				sum_re_s1 <= $signed({a_re[DATA_WIDTH-1], a_re}) - $signed({b_re[DATA_WIDTH-1], b_re});
				sum_im_s1 <= $signed({a_im[DATA_WIDTH-1], a_im}) - $signed({b_im[DATA_WIDTH-1], b_im});
			end else begin
				sum_re_s1 <= $signed({a_re[DATA_WIDTH-1], a_re}) + $signed({b_re[DATA_WIDTH-1], b_re});
				sum_im_s1 <= $signed({a_im[DATA_WIDTH-1], a_im}) + $signed({b_im[DATA_WIDTH-1], b_im});
			end
		end
	end

	always_comb begin
		unique case (func_s1)
			FUNC_ADD, FUNC_SUB: begin
				re_d = {{(NW-DATA_WIDTH){sum_re_s1[DATA_WIDTH]}}, sum_re_s1};
				im_d = {{(NW-DATA_WIDTH){sum_im_s1[DATA_WIDTH]}}, sum_im_s1};
			end
			FUNC_MUL: begin
				re_d = $signed({p_rr_s1[NW-1], p_rr_s1}) - $signed({p_ii_s1[NW-1], p_ii_s1});
				im_d = $signed({p_ri_s1[NW-1], p_ri_s1}) + $signed({p_ir_s1[NW-1], p_ir_s1});
			end
			default: begin
				// Dividend times the conjugate of the divisor.
				re_d = $signed({p_rr_s1[NW-1], p_rr_s1}) + $signed({p_ii_s1[NW-1], p_ii_s1});
				im_d = $signed({p_ir_s1[NW-1], p_ir_s1}) - $signed({p_ri_s1[NW-1], p_ri_s1});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2 <= func_s1;
			re_s2   <= re_d;
			im_s2   <= im_d;
			norm_s2 <= p_bb_s1[NW-1:0] + p_cc_s1[NW-1:0];
		end
	end

	always_comb begin
		mag_re = re_s2[NW] ? NW'(-re_s2) : re_s2[NW-1:0];
		mag_im = im_s2[NW] ? NW'(-im_s2) : im_s2[NW-1:0];
		mag_re_w = {{(CW-NW){1'b0}}, mag_re};
		mag_im_w = {{(CW-NW){1'b0}}, mag_im};
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			out_item.func   <= func_s2;
			out_item.dz     <= (func_s2 == FUNC_DIV) && (norm_s2 == '0);
			out_item.neg_re <= re_s2[NW];
			out_item.neg_im <= im_s2[NW];
			out_item.norm   <= norm_s2;
			unique case (func_s2)
				FUNC_MUL: begin
					out_item.num_re <= mag_re_w >> FRAC_BITS;
					out_item.num_im <= mag_im_w >> FRAC_BITS;
				end
				FUNC_DIV: begin
					out_item.num_re <= mag_re_w << FRAC_BITS;
					out_item.num_im <= mag_im_w << FRAC_BITS;
				end
				default: begin
					out_item.num_re <= mag_re_w;
					out_item.num_im <= mag_im_w;
				end
			endcase
		end
	end

	assign out_valid = v_s3;

endmodule

// ----- rtl/cau_div.sv -----
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage for both parts.
// Items that do not divide pass through with their magnitudes untouched.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output res_item_t out_item
);

	div_stage_t st [NS];
	logic       v  [NS];
	logic       en [NS];

	genvar i;
	generate
		for (i = 0; i < NS; i++) begin : g_stage
			div_stage_t nxt;
			logic [CW-1:0] dsh;

			if (i == NS - 1) begin : g_last
				assign en[i] = !v[i] || out_ready;
			end else begin : g_mid
				assign en[i] = !v[i] || en[i+1];
			end

			if (i == 0) begin : g_ovf
				// Quotient too large for QB bits: it saturates in any case.
				assign dsh = {{(CW-NW){1'b0}}, in_item.norm} << QB;
				always_comb begin
					nxt.func   = in_item.func;
					nxt.dz     = in_item.dz;
					nxt.neg_re = in_item.neg_re;
					nxt.neg_im = in_item.neg_im;
					nxt.rem_re = in_item.num_re;
					nxt.rem_im = in_item.num_im;
					nxt.q_re   = '0;
					nxt.q_im   = '0;
					nxt.ovf_re = in_item.num_re >= dsh;
					nxt.ovf_im = in_item.num_im >= dsh;
					nxt.norm   = in_item.norm;
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) v[i] <= 1'b0;
					else if (en[i]) v[i] <= in_valid;
				end
			end else begin : g_bit
				assign dsh = {{(CW-NW){1'b0}}, st[i-1].norm} << (QB - i);
				always_comb begin
					nxt = st[i-1];
					if (st[i-1].func == FUNC_DIV) begin
						if (st[i-1].rem_re >= dsh) begin
							nxt.rem_re       = st[i-1].rem_re - dsh;
							nxt.q_re[QB - i] = 1'b1;
						end
						if (st[i-1].rem_im >= dsh) begin
							nxt.rem_im       = st[i-1].rem_im - dsh;
							nxt.q_im[QB - i] = 1'b1;
						end
					end
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) v[i] <= 1'b0;
					else if (en[i]) v[i] <= v[i-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[i]) st[i] <= nxt;
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = v[NS-1];

	always_comb begin
		out_item.dz     = st[NS-1].dz;
		out_item.neg_re = st[NS-1].neg_re;
		out_item.neg_im = st[NS-1].neg_im;
		if (st[NS-1].func == FUNC_DIV) begin
			out_item.mag_re = st[NS-1].ovf_re ? CW'(BIG_C) : CW'(st[NS-1].q_re);
			out_item.mag_im = st[NS-1].ovf_im ? CW'(BIG_C) : CW'(st[NS-1].q_im);
		end else begin
			out_item.mag_re = st[NS-1].rem_re;
			out_item.mag_im = st[NS-1].rem_im;
		end
	end

endmodule

// ----- rtl/cau_sat.sv -----
// ----------------------------------------------------------------------------
// cau_sat
// Output stage: saturates both parts, forms the status, holds the result.
// ----------------------------------------------------------------------------
module cau_sat import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  res_item_t                    in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] r_re,
	output logic signed [DATA_WIDTH-1:0] r_im,
	output logic [1:0]                   status
);

	logic                  v_s1;
	logic                  en;
	logic [DATA_WIDTH-1:0] re_d, im_d;
	logic                  sat_re, sat_im;

	function automatic logic [DATA_WIDTH:0] sat_part(input logic neg, input logic [CW-1:0] mag);
		logic [DATA_WIDTH:0] r;
		if (neg) begin
			if (mag > MAXPOS_C + CW'(1)) r = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
			else r = {1'b0, DATA_WIDTH'(~mag[DATA_WIDTH-1:0] + DATA_WIDTH'(1))};
		end else begin
			if (mag > MAXPOS_C) r = {1'b1, 1'b0, {(DATA_WIDTH-1){1'b1}}};
			else r = {1'b0, mag[DATA_WIDTH-1:0]};
		end
		return r;
	endfunction

	assign en       = !v_s1 || out_ready;
	assign in_ready = en;

	always_comb begin
		{sat_re, re_d} = sat_part(in_item.neg_re, in_item.mag_re);
		{sat_im, im_d} = sat_part(in_item.neg_im, in_item.mag_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (in_item.dz) begin
				r_re   <= '0;
				r_im   <= '0;
				status <= STATUS_DZ;
			end else begin
				r_re   <= re_d;
				r_im   <= im_d;
				status <= (sat_re || sat_im) ? STATUS_SAT : STATUS_OK;
			end
		end
	end

	assign out_valid = v_s1;

endmodule

// ----- rtl/complex_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Complex add, subtract, multiply and divide on signed Q8.8 operands.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) takes one beat per cycle while
// in_ready is high: an operation code and two complex operands. The output
// channel (out_valid/out_ready) returns one beat per input beat, in order:
// the saturated real and imaginary parts and a status.
// Every operation takes the same path from acceptance to result: three
// front stages (products, sums, sign split), 18 divider stages (one
// overflow check plus one quotient bit per stage, width plus one bits) and
// the saturating output register. One beat per cycle passes when unstalled.
// Each stage advances whenever the stage after it is free, so when the
// receiver stalls the pipeline keeps filling its empty stages and in_ready
// falls only once all 22 stages hold beats.
// Reset clears all valid bits; the pipeline is empty and ready right after.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] r_re,
	output logic signed [DATA_WIDTH-1:0] r_im,
	output logic [1:0]                   status
);

	div_item_t front_item;
	res_item_t div_item;
	logic      front_valid, front_ready;
	logic      div_valid, div_ready;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	cau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_item  (div_item)
	);

	cau_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_item   (div_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.r_re      (r_re),
		.r_im      (r_im),
		.status    (status)
	);

endmodule

// ----- rtl/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the result channel of the complex ALU.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [DATA_WIDTH-1:0] r_re,
	input logic signed [DATA_WIDTH-1:0] r_im,
	input logic [1:0]                   status
);

	localparam logic signed [DATA_WIDTH-1:0] MAX_C = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MIN_C = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r_re) && $stable(r_im)
			&& $stable(status))
		else $error("result beat changed while stalled");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_DZ |-> r_re == '0 && r_im == '0)
		else $error("division by zero with nonzero result");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_SAT |->
			r_re == MAX_C || r_re == MIN_C || r_im == MAX_C || r_im == MIN_C)
		else $error("saturated status without a clamped part");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_SAT || status == STATUS_DZ)
		else $error("undefined status code");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
